[sv/cdad_pkg.sv]
// Package for the date-advance block: microcode ROM, step types and calendar helpers.
`timescale 1ns / 1ps
package cdad_pkg;

    localparam int PC_W = 3;
    typedef logic [PC_W-1:0] pc_t;

    typedef enum logic [2:0] {
        OP_LOAD,
        OP_MOD,
        OP_SUM,
        OP_YEAR,
        OP_MONTH,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        CD_IN_VALID,
        CD_K_ZERO,
        CD_SUM_DONE,
        CD_YEAR_DONE,
        CD_MONTH_DONE,
        CD_OUT_FREE
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        pc_t   target;
    } uword_t;

    localparam pc_t PC_IDLE  = 3'd0;
    localparam pc_t PC_MOD   = 3'd1;
    localparam pc_t PC_SUM   = 3'd2;
    localparam pc_t PC_YEAR  = 3'd3;
    localparam pc_t PC_MONTH = 3'd4;
    localparam pc_t PC_EMIT  = 3'd5;

    localparam int YEAR_W   = 14;
    localparam int YWALK_W  = 15;
    localparam int REM_W    = 16;
    localparam int R400_W   = 9;
    localparam int CYCLE    = 400;
    localparam int K_TOP    = 5;
    localparam int LAST_MON = 12;

    // a step loops on itself until its condition holds, then jumps
    function automatic uword_t ucode_rd(input pc_t pc);
        uword_t w;
        unique case (pc)
            PC_IDLE:  w = '{op: OP_LOAD,  cond: CD_IN_VALID,   target: PC_MOD};
            PC_MOD:   w = '{op: OP_MOD,   cond: CD_K_ZERO,     target: PC_SUM};
            PC_SUM:   w = '{op: OP_SUM,   cond: CD_SUM_DONE,   target: PC_YEAR};
            PC_YEAR:  w = '{op: OP_YEAR,  cond: CD_YEAR_DONE,  target: PC_MONTH};
            PC_MONTH: w = '{op: OP_MONTH, cond: CD_MONTH_DONE, target: PC_EMIT};
            PC_EMIT:  w = '{op: OP_EMIT,  cond: CD_OUT_FREE,   target: PC_IDLE};
            default:  w = '{op: OP_LOAD,  cond: CD_IN_VALID,   target: PC_IDLE};
        endcase
        return w;
    endfunction

    // leap test on year mod 400
    function automatic logic is_leap(input logic [R400_W-1:0] r);
        return (r[1:0] == 2'd0) &&
               (r != R400_W'(100)) && (r != R400_W'(200)) && (r != R400_W'(300));
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:    len = leap ? 5'd29 : 5'd28;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

[sv/calendar_date_add_days.sv]
// Date advance: start date plus a day count gives a later Gregorian date.
// Usage:
//   Input beat (s_valid/s_ready): s_start_day, s_start_month, s_start_year,
//   s_days_to_add. Result beat (m_valid/m_ready): m_result_day,
//   m_result_month, m_result_year, one per input beat.
//   A small microcode ROM steps one datapath through: load, year mod 400,
//   month-length sum over the preceding months, year walk (a whole year at
//   a time), month walk (a whole month at a time), emit.
//   One item is in work at a time; s_ready is high only in the load step,
//   so the next item is taken as soon as the result sits in the output
//   register, even while the receiver still holds it.
//   Reset (aresetn low, synchronous) returns to the load step and drops
//   m_valid. When the receiver stalls, the result holds and the block waits
//   in its emit step until the output register is free.
`timescale 1ns / 1ps
module calendar_date_add_days (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [4:0]  s_start_day,
    input  logic [3:0]  s_start_month,
    input  logic [13:0] s_start_year,
    input  logic [14:0] s_days_to_add,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [4:0]  m_result_day,
    output logic [3:0]  m_result_month,
    output logic [13:0] m_result_year
);
    import cdad_pkg::*;

    pc_t                pc_reg, pc_next;
    logic               m_valid_reg, m_valid_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [3:0]         month_reg, month_next;
    logic [3:0]         mcnt_reg, mcnt_next;
    logic [YWALK_W-1:0] year_reg, year_next;
    logic [YEAR_W-1:0]  mod_reg, mod_next;
    logic [2:0]         k_reg, k_next;
    logic [4:0]         day_out_reg, day_out_next;
    logic [3:0]         mon_out_reg, mon_out_next;
    logic [YEAR_W-1:0]  year_out_reg, year_out_next;

    uword_t             uw;
    logic               go;
    logic               leap;
    logic [4:0]         mlen;
    logic [8:0]         ylen;
    logic [YWALK_W-1:0] mod_sub;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg      <= PC_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            pc_reg      <= pc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg      <= rem_next;
        month_reg    <= month_next;
        mcnt_reg     <= mcnt_next;
        year_reg     <= year_next;
        mod_reg      <= mod_next;
        k_reg        <= k_next;
        day_out_reg  <= day_out_next;
        mon_out_reg  <= mon_out_next;
        year_out_reg <= year_out_next;
    end

    always_comb begin
        uw      = ucode_rd(pc_reg);
        leap    = is_leap(mod_reg[R400_W-1:0]);
        mlen    = month_len(mcnt_reg, leap);
        ylen    = leap ? 9'd366 : 9'd365;
        mod_sub = YWALK_W'(CYCLE) << k_reg;

        unique case (uw.cond)
            CD_IN_VALID:   go = s_valid;
            CD_K_ZERO:     go = (k_reg == 3'd0);
            CD_SUM_DONE:   go = (mcnt_reg >= month_reg);
            CD_YEAR_DONE:  go = (rem_reg <= REM_W'(ylen));
            CD_MONTH_DONE: go = (mcnt_reg == 4'(LAST_MON)) || (rem_reg <= REM_W'(mlen));
            CD_OUT_FREE:   go = !m_valid_reg || m_ready;
            default:       go = 1'b0;
        endcase
        pc_next = go ? uw.target : pc_reg;

        rem_next      = rem_reg;
        month_next    = month_reg;
        mcnt_next     = mcnt_reg;
        year_next     = year_reg;
        mod_next      = mod_reg;
        k_next        = k_reg;
        day_out_next  = day_out_reg;
        mon_out_next  = mon_out_reg;
        year_out_next = year_out_reg;
        m_valid_next  = m_valid_reg && !m_ready;

        unique case (uw.op)
            OP_LOAD: begin
                if (s_valid) begin
                    rem_next   = REM_W'(s_start_day) + REM_W'(s_days_to_add);
                    month_next = s_start_month;
                    mcnt_next  = 4'd1;
                    year_next  = YWALK_W'(s_start_year);
                    mod_next   = s_start_year;
                    k_next     = 3'(K_TOP);
                end
            end
            OP_MOD: begin
                if (YWALK_W'(mod_reg) >= mod_sub) begin
                    mod_next = YEAR_W'(YWALK_W'(mod_reg) - mod_sub);
                end
                k_next = k_reg - 3'd1;
            end
            OP_SUM: begin
                if (go) begin
                    mcnt_next = 4'd1;
                end else begin
                    rem_next  = rem_reg + REM_W'(mlen);
                    mcnt_next = mcnt_reg + 4'd1;
                end
            end
            OP_YEAR: begin
                if (!go) begin
                    rem_next  = rem_reg - REM_W'(ylen);
                    year_next = year_reg + YWALK_W'(1);
                    mod_next  = (mod_reg == YEAR_W'(CYCLE - 1)) ? '0 : mod_reg + YEAR_W'(1);
                end
            end
            OP_MONTH: begin
                if (!go) begin
                    rem_next  = rem_reg - REM_W'(mlen);
                    mcnt_next = mcnt_reg + 4'd1;
                end
            end
            OP_EMIT: begin
                if (go) begin
                    day_out_next  = rem_reg[4:0];
                    mon_out_next  = mcnt_reg;
                    year_out_next = year_reg[YEAR_W-1:0];
                    m_valid_next  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign s_ready        = (uw.op == OP_LOAD);
    assign m_valid        = m_valid_reg;
    assign m_result_day   = day_out_reg;
    assign m_result_month = mon_out_reg;
    assign m_result_year  = year_out_reg;

endmodule

[sv/cdad_checker.sv]
// Port-level checker for the date-advance block, bound to its top level.
`timescale 1ns / 1ps
module cdad_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [3:0]  m_result_month,
    input logic [13:0] m_result_year
);

    a_reset_no_beat: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat pending right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_year))
        else $error("stalled result beat changed");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second input beat taken while one is in work");

    a_month_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_result_month >= 4'd1) && (m_result_month <= 4'd12))
        else $error("result month out of range");

endmodule

bind calendar_date_add_days cdad_checker u_cdad_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_result_month (m_result_month),
    .m_result_year  (m_result_year)
);

[tb/tb_calendar_date_add_days.sv]
// Testbench for calendar_date_add_days: directed and random date advances checked against a predictor.
`timescale 1ns / 1ps
module tb_calendar_date_add_days;
    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 12;
    localparam int RANDOM_ITEMS   = 1780;
    localparam int QUIET_ITEMS    = 250;
    localparam int HOLD_AFTER     = 500;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_CYCLES   = 150;
    localparam int TIMEOUT_CYCLES = 1500000;
    localparam int PRINT_CAP      = 50;

    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
    } date_t;

    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic [14:0] add;
        logic        typed;
        date_t       want;
    } stim_row_t;

    localparam date_t NO_DATE = '0;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [4:0]  s_start_day = '0;
    logic [3:0]  s_start_month = '0;
    logic [13:0] s_start_year = '0;
    logic [14:0] s_days_to_add = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [4:0]  m_result_day;
    logic [3:0]  m_result_month;
    logic [13:0] m_result_year;

    date_t pending_dates[$];
    logic  beat_typed = 1'b0;
    date_t beat_ref = '0;
    bit    quiet = 1'b0;
    bit    hold_done = 1'b0;
    int    gap_pct = 20;
    int    stall_pct = 15;
    int    mismatches = 0;
    int    results_checked = 0;
    int    beats_sent = 0;

    // typed rows: expected date read straight off the calendar rules
    stim_row_t directed_rows [25] = '{
        '{5'd1,  4'd1,  14'd2000,  15'd0,     1'b1, '{5'd1,  4'd1,  14'd2000}},
        '{5'd0,  4'd0,  14'd5,     15'd0,     1'b1, '{5'd0,  4'd1,  14'd5}},
        '{5'd0,  4'd1,  14'd2023,  15'd0,     1'b1, '{5'd0,  4'd1,  14'd2023}},
        '{5'd31, 4'd12, 14'd9999,  15'd0,     1'b1, '{5'd31, 4'd12, 14'd9999}},
        '{5'd31, 4'd12, 14'd9999,  15'd1,     1'b1, '{5'd1,  4'd1,  14'd10000}},
        '{5'd1,  4'd1,  14'd1,     15'd32767, 1'b0, NO_DATE},
        '{5'd31, 4'd15, 14'd16383, 15'd32767, 1'b0, NO_DATE},
        '{5'd1,  4'd13, 14'd2001,  15'd0,     1'b1, '{5'd1,  4'd1,  14'd2002}},
        '{5'd5,  4'd0,  14'd2001,  15'd0,     1'b1, '{5'd5,  4'd1,  14'd2001}},
        '{5'd31, 4'd2,  14'd2001,  15'd0,     1'b0, NO_DATE},
        '{5'd31, 4'd12, 14'd2000,  15'd0,     1'b1, '{5'd31, 4'd12, 14'd2000}},
        '{5'd29, 4'd2,  14'd2000,  15'd0,     1'b1, '{5'd29, 4'd2,  14'd2000}},
        '{5'd28, 4'd2,  14'd1900,  15'd1,     1'b1, '{5'd1,  4'd3,  14'd1900}},
        '{5'd28, 4'd2,  14'd2004,  15'd1,     1'b1, '{5'd29, 4'd2,  14'd2004}},
        '{5'd28, 4'd2,  14'd0,     15'd1,     1'b1, '{5'd29, 4'd2,  14'd0}},
        '{5'd31, 4'd15, 14'd0,     15'd32767, 1'b0, NO_DATE},
        '{5'd0,  4'd15, 14'd16383, 15'd0,     1'b1, '{5'd31, 4'd12, 14'd16383}},
        '{5'd31, 4'd12, 14'd16383, 15'd1,     1'b1, '{5'd1,  4'd1,  14'd0}},
        '{5'd0,  4'd3,  14'd2001,  15'd0,     1'b1, '{5'd28, 4'd2,  14'd2001}},
        '{5'd1,  4'd1,  14'd1999,  15'd365,   1'b1, '{5'd1,  4'd1,  14'd2000}},
        '{5'd31, 4'd12, 14'd1999,  15'd1,     1'b1, '{5'd1,  4'd1,  14'd2000}},
        '{5'd0,  4'd2,  14'd2001,  15'd0,     1'b1, '{5'd31, 4'd1,  14'd2001}},
        '{5'd15, 4'd7,  14'd2020,  15'd1000,  1'b0, NO_DATE},
        '{5'd21, 4'd10, 14'd10922, 15'd21845, 1'b0, NO_DATE},
        '{5'd10, 4'd5,  14'd5461,  15'd10922, 1'b0, NO_DATE}
    };

    calendar_date_add_days i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_start_day    (s_start_day),
        .s_start_month  (s_start_month),
        .s_start_year   (s_start_year),
        .s_days_to_add  (s_days_to_add),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_day   (m_result_day),
        .m_result_month (m_result_month),
        .m_result_year  (m_result_year)
    );

    always begin
        #(CLK_PERIOD / 2) aclk = 1'b1;
        #(CLK_PERIOD / 2) aclk = 1'b0;
    end

    function automatic bit is_leap_year(input int unsigned y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function automatic int unsigned days_in_year(input int unsigned y);
        return is_leap_year(y) ? 366 : 365;
    endfunction

    function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
        int unsigned len;
        case (m)
            1, 3, 5, 7, 8, 10, 12: len = 31;
            4, 6, 9, 11:           len = 30;
            2:                     len = is_leap_year(y) ? 29 : 28;
            default:               len = 0;
        endcase
        return len;
    endfunction

    // year walk runs on the full year; only the low 14 bits come out
    function automatic date_t advance_date(input logic [4:0] d, input logic [3:0] m,
                                           input logic [13:0] y, input logic [14:0] n);
        date_t       r;
        int unsigned rem;
        int unsigned yr;
        int unsigned mon;
        rem = d + n;
        yr = y;
        for (mon = 1; mon < m; mon++)
            rem += days_in_month(yr, mon);
        while (rem > days_in_year(yr)) begin
            rem -= days_in_year(yr);
            yr++;
        end
        mon = 1;
        while (mon < 12 && rem > days_in_month(yr, mon)) begin
            rem -= days_in_month(yr, mon);
            mon++;
        end
        r.day = 5'(rem);
        r.month = 4'(mon);
        r.year = 14'(yr);
        return r;
    endfunction

    function automatic int pick_pct(input int a, input int b, input int c);
        int sel;
        sel = $urandom_range(2);
        return (sel == 0) ? a : (sel == 1) ? b : c;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_CAP)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatches++;
    endtask

    // called at a falling edge; returns at the falling edge after the beat is taken
    task automatic send_beat(input logic [4:0] d, input logic [3:0] m, input logic [13:0] y,
                             input logic [14:0] n, input logic typed, input date_t want);
        if (!quiet && $urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_start_day <= d;
        s_start_month <= m;
        s_start_year <= y;
        s_days_to_add <= n;
        beat_typed <= typed;
        beat_ref <= want;
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
        @(negedge aclk);
    endtask

    task automatic random_beat();
        logic [4:0]  d;
        logic [3:0]  m;
        logic [13:0] y;
        logic [14:0] n;
        int          kind;
        kind = $urandom_range(99);
        if (kind < 70) begin
            d = 5'($urandom_range(1, 31));
            m = 4'($urandom_range(1, 12));
            y = 14'($urandom_range(1, 9999));
            n = 15'($urandom_range(0, 32767));
        end else if (kind < 88) begin
            // month and year ends, leap boundaries
            d = 5'($urandom_range(27, 31));
            m = $urandom_range(1) ? 4'd2 : 4'd12;
            case ($urandom_range(4))
                0:       y = 14'd0;
                1:       y = 14'(100 * $urandom_range(1, 163));
                2:       y = 14'(4 * $urandom_range(0, 4095));
                3:       y = 14'(16383 - $urandom_range(0, 3));
                default: y = 14'($urandom_range(1, 9999));
            endcase
            n = $urandom_range(1) ? 15'($urandom_range(0, 3)) : 15'($urandom_range(364, 367));
        end else begin
            d = 5'($urandom);
            m = 4'($urandom);
            y = 14'($urandom);
            n = 15'($urandom);
        end
        send_beat(d, m, y, n, 1'b0, NO_DATE);
    endtask

    task automatic wait_drain();
        do @(negedge aclk); while (pending_dates.size() != 0);
    endtask

    always @(posedge aclk) begin
        date_t got;
        date_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = '{m_result_day, m_result_month, m_result_year};
                if (pending_dates.size() == 0) begin
                    report_mismatch($sformatf("result %0d/%0d/%0d with none pending",
                                              got.day, got.month, got.year));
                end else begin
                    want = pending_dates.pop_front();
                    if (got.day !== want.day)
                        report_mismatch($sformatf("result %0d day %0d, want %0d",
                                                  results_checked, got.day, want.day));
                    if (got.month !== want.month)
                        report_mismatch($sformatf("result %0d month %0d, want %0d",
                                                  results_checked, got.month, want.month));
                    if (got.year !== want.year)
                        report_mismatch($sformatf("result %0d year %0d, want %0d",
                                                  results_checked, got.year, want.year));
                    results_checked++;
                end
            end
            if (s_valid && s_ready)
                pending_dates.push_back(beat_typed ? beat_ref :
                    advance_date(s_start_day, s_start_month, s_start_year, s_days_to_add));
        end
    end

    initial begin : result_side
        int stall_left;
        int cyc;
        stall_left = 0;
        cyc = 0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            cyc++;
            if (cyc % 128 == 0)
                stall_pct = pick_pct(0, 15, 40);
            // long back-pressure: the block fills and drops s_ready
            if (!hold_done && results_checked >= HOLD_AFTER) begin
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
            end
            if (stall_left == 0 && !quiet && $urandom_range(99) < stall_pct)
                stall_left = $urandom_range(1, 6);
            if (stall_left != 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        foreach (directed_rows[i])
            send_beat(directed_rows[i].day, directed_rows[i].month, directed_rows[i].year,
                      directed_rows[i].add, directed_rows[i].typed, directed_rows[i].want);
        s_valid <= 1'b0;
        wait_drain();
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 64 == 0)
                gap_pct = pick_pct(0, 20, 50);
            if (i == RANDOM_ITEMS / 2) begin
                s_valid <= 1'b0;
                wait_drain();
            end
            quiet = (i >= RANDOM_ITEMS - QUIET_ITEMS);
            random_beat();
        end
        s_valid <= 1'b0;
        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_dates.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_dates.size()));
        $display("Sent %0d date beats (%0d directed, %0d random), checked %0d results.",
                 beats_sent, $size(directed_rows), RANDOM_ITEMS, results_checked);
        $display("Covered leap rules, month 0 and 13..15, day rollover, year wrap, %0d-cycle stall.",
                 LONG_HOLD);
        if (mismatches == 0)
            $display("calendar_date_add_days verification clean");
        else
            $display("calendar_date_add_days verification failed");
        $finish;
    end

    initial begin : watchdog
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("Timeout after %0d cycles.", TIMEOUT_CYCLES);
        $display("calendar_date_add_days verification failed");
        $finish;
    end
endmodule

[sim.f]
sv/cdad_pkg.sv
sv/calendar_date_add_days.sv
sv/cdad_checker.sv
tb/tb_calendar_date_add_days.sv
